/* rtl/core/aagc_pkg.sv */
package aagc_pkg;

    localparam int unsigned GAIN_W   = 3;
    localparam int unsigned SMP_W    = 16;
    localparam int unsigned CH_W     = 2;
    localparam int unsigned UV_W     = 24;
    localparam int unsigned FS_W     = 23;
    localparam int unsigned QUO_W    = 23;
    // mag * full scale + rounding bias stays below 2^38
    localparam int unsigned NUM_W    = 38;
    localparam int unsigned CWORD_W  = 16;
    localparam int unsigned RATE_W   = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [GAIN_W-1:0] MAX_LEVEL = 3'd5;
    localparam logic [SMP_W-1:0]  HIGH_MARK = 16'd26214;
    localparam logic [SMP_W-1:0]  LOW_MARK  = 16'd6553;
    localparam logic [14:0]       CODE_MAX  = 15'd32767;
    localparam logic [14:0]       ROUND_BIAS = 15'd16383;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGC_ENABLE   = 2'd0,
        CFG_DIFFERENTIAL = 2'd1,
        CFG_DATA_RATE    = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    // gain lookup result for the item in the input register
    typedef struct packed {
        logic [GAIN_W-1:0] used;
        logic [GAIN_W-1:0] nxt;
    } t_gain_res;

    // full scale in microvolts per gain level
    function automatic logic [FS_W-1:0] full_scale_uv(input logic [GAIN_W-1:0] level);
        logic [FS_W-1:0] fs;
        case (level)
            3'd0:    fs = 23'd6144000;
            3'd1:    fs = 23'd4096000;
            3'd2:    fs = 23'd2048000;
            3'd3:    fs = 23'd1024000;
            3'd4:    fs = 23'd512000;
            default: fs = 23'd256000;
        endcase
        return fs;
    endfunction

endpackage

/* rtl/core/aagc_gain_ctl.sv */
module aagc_gain_ctl #(
    parameter int unsigned NUM_CHANNELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [aagc_pkg::CH_W-1:0]     i_ch,
    input  logic [aagc_pkg::SMP_W-1:0]    i_mag,
    input  logic                          i_agc_en,
    input  logic                          i_upd,
    output aagc_pkg::t_gain_res           o_res
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [aagc_pkg::GAIN_W-1:0] r_gain [NUM_CHANNELS];
    logic                        ch_ok;
    logic [IDX_W-1:0]            idx;
    logic [aagc_pkg::GAIN_W-1:0] stored;
    logic [aagc_pkg::GAIN_W-1:0] lvl;
    logic [aagc_pkg::GAIN_W-1:0] n_gain;

    assign ch_ok = ({1'b0, i_ch} < (aagc_pkg::CH_W+1)'(NUM_CHANNELS));
    assign idx   = IDX_W'(i_ch);

    always_comb begin
        stored = ch_ok ? r_gain[idx] : '0;
        lvl    = (stored > aagc_pkg::MAX_LEVEL) ? aagc_pkg::MAX_LEVEL : stored;
        n_gain = lvl;
        if (ch_ok && i_agc_en) begin
            if ((i_mag >= aagc_pkg::HIGH_MARK) && (lvl != '0)) begin
                n_gain = lvl - 3'd1;
            end else if ((i_mag <= aagc_pkg::LOW_MARK) && (lvl < aagc_pkg::MAX_LEVEL)) begin
                n_gain = lvl + 3'd1;
            end
        end
    end

    assign o_res.used = lvl;
    assign o_res.nxt  = n_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_gain[i] <= '0;
            end
        end else if (i_upd && ch_ok && i_agc_en) begin
            r_gain[idx] <= n_gain;
        end
    end

endmodule

/* rtl/core/aagc_uv_conv.sv */
module aagc_uv_conv (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [aagc_pkg::GAIN_W-1:0]  i_level,
    input  logic [aagc_pkg::SMP_W-1:0]   i_mag,
    input  logic                         i_neg,
    output logic [aagc_pkg::UV_W-1:0]    o_uv
);

    logic [aagc_pkg::FS_W-1:0]   fs;
    logic [38:0]                 prod;
    logic [aagc_pkg::NUM_W-1:0]  n_y;
    logic [aagc_pkg::NUM_W-1:0]  r_y;
    logic                        r_neg;

    // fold to divide by 2^15-1: y = a*32768 + b = a*32767 + (a+b)
    logic [22:0]                 a_hi;
    logic [23:0]                 s1;
    logic [8:0]                  c_hi;
    logic [15:0]                 t_lo;
    logic [aagc_pkg::QUO_W-1:0]  quo;

    assign fs   = aagc_pkg::full_scale_uv(i_level);
    assign prod = {23'd0, i_mag} * {16'd0, fs};
    assign n_y  = prod[aagc_pkg::NUM_W-1:0] + aagc_pkg::NUM_W'(aagc_pkg::ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y   <= n_y;
            r_neg <= i_neg;
        end
    end

    always_comb begin
        a_hi = r_y[37:15];
        s1   = {1'b0, a_hi} + {9'd0, r_y[14:0]};
        c_hi = s1[23:15];
        t_lo = {7'd0, c_hi} + {1'b0, s1[14:0]};
        quo  = a_hi + {14'd0, c_hi}
             + ((t_lo >= {1'b0, aagc_pkg::CODE_MAX}) ? 23'd1 : 23'd0);
        o_uv = r_neg ? (24'd0 - {1'b0, quo}) : {1'b0, quo};
    end

endmodule

/* rtl/core/adc_autorange_gain_control_unit.sv */
// Automatic gain ranging for a four-channel 16-bit converter.
// Slave stream: one conversion result per transfer (channel, signed sample).
// Master stream: one result per input: the single-shot config word built
// with the gain in force before the sample, the voltage in microvolts
// (full scale * sample / 32767, rounded half away from zero), the gain
// used and the gain stored for the channel afterwards.
// Config port: index/data writes; take them only while the pipe is empty.
// Pipeline: input register -> product register -> output register; a
// result passes all three before it is valid on the master side. One
// transfer per cycle sustained while the master side keeps ready high;
// the per-channel gain is read and written at the input
// register, so a result for the same channel right behind sees the update.
// The 23x16 multiply sits between the input and product registers.
// Reset clears all gain levels to 0, all config registers to 0 and the
// pipeline valids. When the master side stalls, each stage holds only
// while its successor is full, so bubbles still fill and input is taken
// until all three stages are occupied.
module adc_autorange_gain_control_unit #(
    parameter int unsigned NUM_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: [1:0] channel, [17:2] adc_sample, [23:18] zero
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,
    // tdata: [15:0] config_word, [39:16] voltage_microvolts,
    //        [42:40] gain_used, [45:43] gain_next, [47:46] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [aagc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aagc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic                          r_agc_en;
    logic                          r_diff;
    logic [aagc_pkg::RATE_W-1:0]   r_rate;

    // stage 1: input register
    logic                          r_v1;
    logic [aagc_pkg::CH_W-1:0]     r_ch;
    logic [aagc_pkg::SMP_W-1:0]    r_smp;

    // stage 2: product register side info
    logic                          r_v2;
    logic [aagc_pkg::CWORD_W-1:0]  r_word2;
    aagc_pkg::t_gain_res           r_gain2;

    // stage 3: output register
    logic                          r_v3;
    logic [aagc_pkg::CWORD_W-1:0]  r_word3;
    logic [aagc_pkg::UV_W-1:0]     r_uv3;
    aagc_pkg::t_gain_res           r_gain3;

    logic                          rdy1, rdy2, rdy3;
    logic                          acc_in, adv1, adv2;
    logic                          neg1;
    logic [aagc_pkg::SMP_W-1:0]    mag1;
    logic [aagc_pkg::CWORD_W-1:0]  n_word2;
    aagc_pkg::t_gain_res           gres;
    logic [aagc_pkg::UV_W-1:0]     uv2;

    // per-stage ready chain: a stage may load when empty or draining
    assign rdy3   = !r_v3 || i_m_axis_tready;
    assign adv2   = r_v2 && rdy3;
    assign rdy2   = !r_v2 || rdy3;
    assign adv1   = r_v1 && rdy2;
    assign rdy1   = !r_v1 || rdy2;
    assign acc_in = i_s_axis_tvalid && rdy1;

    assign o_s_axis_tready = rdy1;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agc_en <= 1'b0;
            r_diff   <= 1'b0;
            r_rate   <= '0;
        end else if (i_cfg_valid) begin
            unique case (aagc_pkg::t_cfg_idx'(i_cfg_index))
                aagc_pkg::CFG_AGC_ENABLE:   r_agc_en <= i_cfg_data[0];
                aagc_pkg::CFG_DIFFERENTIAL: r_diff   <= i_cfg_data[0];
                aagc_pkg::CFG_DATA_RATE:    r_rate   <= i_cfg_data[aagc_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_ch  <= i_s_axis_tdata[1:0];
            r_smp <= i_s_axis_tdata[17:2];
        end
    end

    assign neg1 = r_smp[aagc_pkg::SMP_W-1];
    // -32768 maps to 0x8000, which is the unsigned magnitude
    assign mag1 = neg1 ? (16'd0 - r_smp) : r_smp;

    aagc_gain_ctl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_gain_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch     (r_ch),
        .i_mag    (mag1),
        .i_agc_en (r_agc_en),
        .i_upd    (adv1),
        .o_res    (gres)
    );

    // start, single-ended, channel, gain, single-shot, rate, zeros
    assign n_word2 = {1'b1, !r_diff, r_ch, gres.used, 1'b1, r_rate, 5'd0};

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_word2 <= n_word2;
            r_gain2 <= gres;
        end
    end

    aagc_uv_conv u_uv_conv (
        .i_clk   (i_clk),
        .i_en    (adv1),
        .i_level (gres.used),
        .i_mag   (mag1),
        .i_neg   (neg1),
        .o_uv    (uv2)
    );

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_word3 <= r_word2;
            r_uv3   <= uv2;
            r_gain3 <= r_gain2;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {2'b00, r_gain3.nxt, r_gain3.used, r_uv3, r_word3};

    // gain moves by at most one step per sample
    a_gain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((r_gain3.nxt == r_gain3.used) ||
                  (r_gain3.nxt == r_gain3.used + 3'd1) ||
                  (r_gain3.nxt + 3'd1 == r_gain3.used)))
        else $error("gain stepped by more than one level");

    // with stepping off the stored level never changes
    a_agc_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_agc_en) |-> (r_gain3.nxt == r_gain3.used))
        else $error("gain changed with automatic gain off");

    // config word gain field matches the gain used
    a_word_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_word3[11:9] == r_gain3.used))
        else $error("config word gain mismatch");

    // a blocked input register keeps its item
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !rdy2) |=> (r_v1 && $stable(r_ch) && $stable(r_smp)))
        else $error("input register lost a stalled item");

endmodule

/* tb/testbench.sv */
module testbench;

    localparam int unsigned CHANNELS       = 4;
    localparam int unsigned PHASES         = 10;
    localparam int unsigned PHASE_ITEMS    = 95;
    localparam int unsigned TAIL_CYCLES    = 8;       // pipe is 3 deep, plus margin
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned STEP_DOWN_MARK = 26214;
    localparam int unsigned STEP_UP_MARK   = 6553;
    localparam logic [2:0]  TOP_LEVEL      = 3'd5;

    // one result transfer, laid out MSB first exactly as o_m_axis_tdata
    typedef struct packed {
        logic [1:0]         pad;
        logic [2:0]         gain_next;
        logic [2:0]         gain_used;
        logic signed [23:0] uv;
        logic [15:0]        cword;
    } t_result;

    typedef enum logic {ROW_SAMPLE, ROW_REG} t_row_kind;

    // directed stimulus row; 'typed' rows carry a hand-written expectation
    typedef struct packed {
        t_row_kind            kind;
        logic [1:0]           ch;
        logic [15:0]          smp;
        aagc_pkg::t_cfg_idx   idx;
        logic [7:0]           data;
        logic                 typed;
        t_result              want;
    } t_row;

    // ---------------------------------------------------------------- DUT I/O
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    aagc_pkg::t_cfg_idx cfg_index = aagc_pkg::CFG_AGC_ENABLE;
    logic [aagc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [47:0] m_tdata;
    wire         cfg_ready;

    // ------------------------------------------------------ predictor state
    logic [2:0]  gain_store [CHANNELS] = '{default: 3'd0};
    logic        agc_on  = 1'b0;
    logic        diff_on = 1'b0;
    logic [2:0]  rate    = 3'd0;

    t_result     pending [$];     // expected results, oldest first
    int unsigned errors      = 0;
    int unsigned cycles      = 0;
    logic        sink_steady = 1'b0;

    always #5 clk = ~clk;

    adc_autorange_gain_control_unit #(
        .NUM_CHANNELS(CHANNELS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // Gain ranging and microvolt conversion for one accepted sample. The
    // config word and the voltage use the level in force before the sample;
    // the stored level may then step by one level, only with automatic gain on.
    function automatic t_result range_and_convert(input logic [1:0] ch,
                                                  input logic [15:0] smp);
        t_result     r;
        logic [2:0]  lvl;
        logic [2:0]  nxt;
        logic [16:0] mag;
        logic [63:0] fs;
        logic [63:0] prod;
        logic [63:0] quo;
        lvl = 3'd0;
        if (ch < CHANNELS) begin
            lvl = (gain_store[ch] > TOP_LEVEL) ? TOP_LEVEL : gain_store[ch];
        end
        nxt = lvl;
        // -32768 has magnitude 32768, hence 17 bits
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        if (ch < CHANNELS && agc_on) begin
            if (mag >= STEP_DOWN_MARK && lvl > 0) begin
                nxt = lvl - 3'd1;
            end else if (mag <= STEP_UP_MARK && lvl < TOP_LEVEL) begin
                nxt = lvl + 3'd1;
            end
            gain_store[ch] = nxt;
        end
        case (lvl)
            3'd0:    fs = 64'd6144000;
            3'd1:    fs = 64'd4096000;
            3'd2:    fs = 64'd2048000;
            3'd3:    fs = 64'd1024000;
            3'd4:    fs = 64'd512000;
            default: fs = 64'd256000;
        endcase
        // round to nearest, half away from zero: (2n + d) / 2d on the magnitude
        prod = fs * 64'(mag);
        quo  = (64'd2 * prod + 64'd32767) / 64'd65534;
        r.pad       = '0;
        r.cword     = {1'b1, ~diff_on, ch, lvl, 1'b1, rate, 5'b0};
        r.uv        = smp[15] ? -quo[23:0] : quo[23:0];
        r.gain_used = lvl;
        r.gain_next = nxt;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Biased toward the step-up and step-down zones so levels walk the full
    // 0..5 span; the rest is threshold edges and plain random codes.
    function automatic logic [15:0] draw_sample();
        logic [15:0] m;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            m = 16'($urandom_range(0, STEP_UP_MARK));
        end else if (pick < 5) begin
            m = 16'($urandom_range(STEP_DOWN_MARK, 32767));
        end else if (pick == 5) begin
            case ($urandom_range(0, 4))
                0:       m = 16'd6553;
                1:       m = 16'd6554;
                2:       m = 16'd26213;
                3:       m = 16'd26214;
                default: m = 16'h8000;
            endcase
        end else begin
            m = 16'($urandom);
        end
        if (pick <= 5 && $urandom_range(0, 1) == 1) begin
            m = -m;
        end
        return m;
    endfunction

    function automatic t_row row_sample(input logic [1:0] ch, input logic [15:0] smp);
        return '{kind: ROW_SAMPLE, ch: ch, smp: smp, idx: aagc_pkg::CFG_AGC_ENABLE,
                 data: 8'd0, typed: 1'b0, want: '0};
    endfunction

    function automatic t_row row_typed(input logic [1:0] ch, input logic [15:0] smp,
                                       input logic [15:0] cw, input logic signed [23:0] uv);
        t_result w;
        w = '{pad: 2'b0, gain_next: 3'd0, gain_used: 3'd0, uv: uv, cword: cw};
        return '{kind: ROW_SAMPLE, ch: ch, smp: smp, idx: aagc_pkg::CFG_AGC_ENABLE,
                 data: 8'd0, typed: 1'b1, want: w};
    endfunction

    function automatic t_row row_reg(input aagc_pkg::t_cfg_idx idx, input logic [7:0] data);
        return '{kind: ROW_REG, ch: 2'd0, smp: 16'd0, idx: idx,
                 data: data, typed: 1'b0, want: '0};
    endfunction

    // Drop valid for the gap given by n, if any. Valid is never lowered elsewhere while items
    // flow, so back-to-back transfers keep it high without a glitch.
    task automatic hold_off(input int unsigned n);
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic push_sample(input logic [1:0] ch, input logic [15:0] smp,
                               input logic typed, input t_result want);
        t_result model;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, smp, ch};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        // transfer done at this edge; predictor always runs to track gains
        model = range_and_convert(ch, smp);
        pending.push_back(typed ? want : model);
    endtask

    // stop sending and wait until every expected result has been seen
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input aagc_pkg::t_cfg_idx idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            aagc_pkg::CFG_AGC_ENABLE:   agc_on  = data[0];
            aagc_pkg::CFG_DIFFERENTIAL: diff_on = data[0];
            aagc_pkg::CFG_DATA_RATE:    rate    = data[2:0];
            default:                    ;   // unused index, write has no effect
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------- master-side pacing
    // Ready runs broken by stalls; steady phases keep ready high throughout.
    initial begin : sink_pacing
        int unsigned run;
        int unsigned stall;
        @(posedge clk);
        forever begin
            if (sink_steady) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end else begin
                run = $urandom_range(1, 16);
                m_tready <= 1'b1;
                repeat (run) @(posedge clk);
                stall = pick_gap();
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------- result checking
    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer, got %h", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.cword !== want.cword) begin
                    $display("%0t: config word expected %h got %h",
                             $time, want.cword, got.cword);
                    errors++;
                end
                if (got.uv !== want.uv) begin
                    $display("%0t: microvolts expected %0d got %0d",
                             $time, want.uv, got.uv);
                    errors++;
                end
                if (got.gain_used !== want.gain_used) begin
                    $display("%0t: gain used expected %0d got %0d",
                             $time, want.gain_used, got.gain_used);
                    errors++;
                end
                if (got.gain_next !== want.gain_next) begin
                    $display("%0t: gain next expected %0d got %0d",
                             $time, want.gain_next, got.gain_next);
                    errors++;
                end
                if (got.pad !== want.pad) begin
                    $display("%0t: pad bits expected %b got %b",
                             $time, want.pad, got.pad);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("adc_autorange_gain_control_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------ stimulus
    initial begin : stimulus
        t_row        dir_rows [$];
        logic [7:0]  agc_d;
        logic [7:0]  diff_d;
        logic [7:0]  rate_d;
        logic        steady;

        // After reset: agc off, single-ended, rate 0, every level 0, so the
        // first rows are read straight off the format. Then the walk through
        // all six levels: up at the low mark, hold just past it, saturate at
        // 5, down at the high mark, hold just below it, saturate at 0.
        dir_rows = '{
            row_typed(2'd0, 16'd0,     16'hC100, 24'sd0),
            row_typed(2'd1, 16'd32767, 16'hD100, 24'sd6144000),
            row_typed(2'd2, 16'h8000,  16'hE100, -24'sd6144188),
            row_typed(2'd3, 16'd1,     16'hF100, 24'sd188),
            row_typed(2'd3, 16'hFFFF,  16'hF100, -24'sd188),
            row_reg(aagc_pkg::CFG_AGC_ENABLE,   8'h01),
            row_reg(aagc_pkg::CFG_DIFFERENTIAL, 8'h01),
            row_reg(aagc_pkg::CFG_DATA_RATE,    8'h07),
            row_reg(aagc_pkg::CFG_UNUSED,       8'hFF),
            row_sample(2'd0, 16'd0),
            row_sample(2'd0, 16'd6553),
            row_sample(2'd0, 16'd6554),
            row_sample(2'd0, -16'sd6553),
            row_sample(2'd0, 16'd100),
            row_sample(2'd0, -16'sd5),
            row_sample(2'd0, 16'd0),
            row_sample(2'd0, 16'd26214),
            row_sample(2'd0, -16'sd26214),
            row_sample(2'd0, 16'd26213),
            row_sample(2'd0, 16'h8000),
            row_sample(2'd0, 16'd32767),
            row_sample(2'd0, 16'd32767),
            row_sample(2'd0, 16'h8000)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                push_sample(dir_rows[i].ch, dir_rows[i].smp,
                            dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random phases; each starts from an empty pipe with a fresh setting.
        // Upper data bits are random since only the low bits are stored.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    agc_d  = {7'($urandom), 1'b1};
                    diff_d = {7'($urandom), 1'b0};
                    rate_d = {5'($urandom), 3'd0};
                end
                1: begin
                    agc_d  = {7'($urandom), 1'b1};
                    diff_d = {7'($urandom), 1'b1};
                    rate_d = {5'($urandom), 3'd7};
                end
                2: begin
                    agc_d  = {7'($urandom), 1'b0};
                    diff_d = {7'($urandom), 1'b0};
                    rate_d = {5'($urandom), 3'd7};
                end
                default: begin
                    agc_d  = 8'($urandom);
                    diff_d = 8'($urandom);
                    rate_d = 8'($urandom);
                end
            endcase
            write_reg(aagc_pkg::CFG_AGC_ENABLE,   agc_d);
            write_reg(aagc_pkg::CFG_DIFFERENTIAL, diff_d);
            write_reg(aagc_pkg::CFG_DATA_RATE,    rate_d);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(aagc_pkg::CFG_UNUSED, 8'($urandom));
            end

            // every fourth phase runs flat out on both sides
            steady      = (p % 4 == 3);
            sink_steady = steady;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 5 && k == PHASE_ITEMS / 2) begin
                    settle();   // let the pipe run dry mid-stream
                end else if (!steady) begin
                    hold_off(pick_gap());
                end
                push_sample(2'($urandom_range(0, CHANNELS - 1)), draw_sample(),
                            1'b0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("adc_autorange_gain_control_unit regression: pass");
        end else begin
            $display("adc_autorange_gain_control_unit regression: fail");
        end
        $finish;
    end

endmodule
